FILE: hdl/camera_basis_rotate_move_unit_defines.svh
// Assertion macros for the camera basis rotate/move unit.
`ifndef CAMERA_BASIS_ROTATE_MOVE_UNIT_DEFINES_SVH
`define CAMERA_BASIS_ROTATE_MOVE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CBRM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CBRM_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBRM_ASSERT(label, clk, rst, prop, msg)
`define CBRM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: hdl/cbrm_pkg.sv
// Shared types, constants and tables for the camera basis unit.
package cbrm_pkg;

   localparam int TrigIterationsDefault = 16;
   localparam int MaxSteps = 24;

   localparam logic [1:0] OP_ROTATE = 2'd0;
   localparam logic [1:0] OP_MOVE   = 2'd1;
   localparam logic [1:0] OP_LOAD   = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] AX_FWD = 2'd0;
   localparam logic [1:0] AX_RGT = 2'd1;
   localparam logic [1:0] AX_UP  = 2'd2;
   localparam logic [1:0] AX_POS = 2'd3;

   localparam logic signed [33:0] Q30HalfPi = 34'sd1686629713;
   localparam logic signed [33:0] Q30Pi     = 34'sd3373259426;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         axis;
      logic signed [15:0] angle;
      logic signed [31:0] distance;
      logic signed [31:0] load_x;
      logic signed [31:0] load_y;
      logic signed [31:0] load_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] look_x;
      logic signed [31:0] look_y;
      logic signed [31:0] look_z;
      logic signed [31:0] up_out_x;
      logic signed [31:0] up_out_y;
      logic signed [31:0] up_out_z;
   } rsp_type;

   // datapath command codes
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_CAPTURE,   // latch request, reduce angle, start cordic
      CMD_CORDIC,    // one cordic step
      CMD_SHIFT,     // position move by one component
      CMD_TURN_A,    // first product of turn for one component
      CMD_TURN_B,    // second product and writeback
      CMD_LOAD,      // load a vector
      CMD_OUTPUT     // register response
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [4:0] step;   // cordic step index
      logic [1:0] comp;   // component index
      logic [2:0] sub;    // product selector inside turn
      logic       src_fwd; // move source is forward (pivot) instead of item axis
      logic       neg;     // negate distance
   } cmd_type;

   function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0: r = 34'sd843314857;
         5'd1: r = 34'sd497837830;
         5'd2: r = 34'sd263043837;
         5'd3: r = 34'sd133525159;
         5'd4: r = 34'sd67021688;
         5'd5: r = 34'sd33543516;
         5'd6: r = 34'sd16775851;
         5'd7: r = 34'sd8388437;
         5'd8: r = 34'sd4194283;
         5'd9: r = 34'sd2097149;
         5'd10: r = 34'sd1048576;
         5'd11: r = 34'sd524288;
         5'd12: r = 34'sd262144;
         5'd13: r = 34'sd131072;
         5'd14: r = 34'sd65536;
         5'd15: r = 34'sd32768;
         5'd16: r = 34'sd16384;
         5'd17: r = 34'sd8192;
         5'd18: r = 34'sd4096;
         5'd19: r = 34'sd2048;
         5'd20: r = 34'sd1024;
         5'd21: r = 34'sd512;
         5'd22: r = 34'sd256;
         5'd23: r = 34'sd128;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/cbrm_datapath.sv
// Datapath: basis registers, cordic, a shared turn multiplier and a move multiplier.
`include "camera_basis_rotate_move_unit_defines.svh"
module cbrm_datapath import cbrm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output logic [1:0] item_op,
   output logic [1:0] item_axis,
   output rsp_type rsp_data
);

   logic signed [31:0] pos_ff [3], pos_in [3];
   logic signed [31:0] fwd_ff [3], fwd_in [3];
   logic signed [31:0] rgt_ff [3], rgt_in [3];
   logic signed [31:0] up_ff  [3], up_in  [3];
   req_type item_ff, item_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic neg_ff, neg_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] na_ff, na_in;
   rsp_type out_ff, out_in;

   logic signed [33:0] theta, sn, cs, dx, dy;
   logic signed [31:0] va, vb, mv;
   logic signed [33:0] coef;
   logic signed [65:0] prod;
   logic signed [63:0] mprod, sum2, stp;
   logic signed [32:0] move_dist;

   assign item_op   = item_ff.op;
   assign item_axis = item_ff.axis;
   assign rsp_data  = out_ff;
   assign sn = neg_ff ? -cy_ff : cy_ff;
   assign cs = neg_ff ? -cx_ff : cx_ff;
   assign dx = cy_ff >>> cmd.step;
   assign dy = cx_ff >>> cmd.step;

   // a = first vector of the pair, b = second
   always_comb begin
      va = fwd_ff[cmd.comp];
      vb = up_ff[cmd.comp];
      case (item_ff.axis)
         AX_FWD: begin va = fwd_ff[cmd.comp]; vb = up_ff[cmd.comp]; end
         AX_RGT: begin va = fwd_ff[cmd.comp]; vb = rgt_ff[cmd.comp]; end
         default: begin va = up_ff[cmd.comp]; vb = rgt_ff[cmd.comp]; end
      endcase
      mv = fwd_ff[cmd.comp];
      if (!cmd.src_fwd) begin
         case (item_ff.axis)
            AX_RGT:  mv = rgt_ff[cmd.comp];
            AX_UP:   mv = up_ff[cmd.comp];
            default: mv = fwd_ff[cmd.comp];
         endcase
      end
   end

   // shared multiplier: 32 x 34 with register after
   // sub 0: a*c, sub 1: b*s, sub 2: b*c, sub 3: -a*s
   always_comb begin
      coef = cs;
      case (cmd.sub)
         3'd0: coef = cs;
         3'd1: coef = sn;
         3'd2: coef = cs;
         default: coef = -sn;
      endcase
      prod = (cmd.sub[0] ^ cmd.sub[1] ? vb : va) * coef;
   end
   assign move_dist = cmd.neg ? -33'(item_ff.distance) : 33'(item_ff.distance);
   assign mprod = 64'(mv) * 64'(move_dist);
   assign sum2  = acc_ff + 64'(prod) + 64'sd536870912;
   assign stp   = (mprod + 64'sd32768) >>> 16;

   always_comb begin
      pos_in = pos_ff; fwd_in = fwd_ff; rgt_in = rgt_ff; up_in = up_ff;
      item_in = item_ff; cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      neg_in = neg_ff; acc_in = acc_ff; na_in = na_ff; out_in = out_ff;
      theta = 34'(req_data.angle) <<< 17;
      case (cmd.op)
         CMD_CAPTURE: begin
            item_in = req_data;
            cx_in = CordicGain; cy_in = '0; neg_in = 1'b0;
            if (theta > Q30HalfPi) begin
               cz_in = theta - Q30Pi; neg_in = 1'b1;
            end else if (theta < -Q30HalfPi) begin
               cz_in = theta + Q30Pi; neg_in = 1'b1;
            end else begin
               cz_in = theta;
            end
         end
         CMD_CORDIC: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - dx; cy_in = cy_ff + dy;
               cz_in = cz_ff - atan_q30(cmd.step);
            end else begin
               cx_in = cx_ff + dx; cy_in = cy_ff - dy;
               cz_in = cz_ff + atan_q30(cmd.step);
            end
         end
         CMD_SHIFT: pos_in[cmd.comp] = pos_ff[cmd.comp] + stp[31:0];
         CMD_TURN_A: acc_in = 64'(prod);
         CMD_TURN_B: begin
            // sub 1: new a (a*c + b*s); sub 3: new b (b*c - a*s)
            if (cmd.sub == 3'd1) begin
               na_in = sum2[61:30];
            end else begin
               case (item_ff.axis)
                  AX_FWD: begin
                     fwd_in[cmd.comp] = na_ff;
                     up_in[cmd.comp]  = sum2[61:30];
                  end
                  AX_RGT: begin
                     fwd_in[cmd.comp] = na_ff;
                     rgt_in[cmd.comp] = sum2[61:30];
                  end
                  default: begin
                     up_in[cmd.comp]  = na_ff;
                     rgt_in[cmd.comp] = sum2[61:30];
                  end
               endcase
            end
         end
         CMD_LOAD: begin
            case (item_ff.axis)
               AX_FWD: begin
                  fwd_in[0] = item_ff.load_x; fwd_in[1] = item_ff.load_y;
                  fwd_in[2] = item_ff.load_z;
               end
               AX_RGT: begin
                  rgt_in[0] = item_ff.load_x; rgt_in[1] = item_ff.load_y;
                  rgt_in[2] = item_ff.load_z;
               end
               AX_UP: begin
                  up_in[0] = item_ff.load_x; up_in[1] = item_ff.load_y;
                  up_in[2] = item_ff.load_z;
               end
               default: begin
                  pos_in[0] = item_ff.load_x; pos_in[1] = item_ff.load_y;
                  pos_in[2] = item_ff.load_z;
               end
            endcase
         end
         CMD_OUTPUT: begin
            out_in.pos_x = pos_ff[0]; out_in.pos_y = pos_ff[1]; out_in.pos_z = pos_ff[2];
            out_in.look_x = pos_ff[0] + fwd_ff[0];
            out_in.look_y = pos_ff[1] + fwd_ff[1];
            out_in.look_z = pos_ff[2] + fwd_ff[2];
            out_in.up_out_x = up_ff[0]; out_in.up_out_y = up_ff[1];
            out_in.up_out_z = up_ff[2];
         end
         default: ;
      endcase
   end

   // new a waits in na until new b is done, since b still needs the old a
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0] <= 32'sh0; pos_ff[1] <= 32'shFFFF0000; pos_ff[2] <= 32'sh00080000;
         fwd_ff[0] <= 32'sh0; fwd_ff[1] <= 32'sh0; fwd_ff[2] <= 32'shFFFF0000;
         rgt_ff[0] <= 32'sh00010000; rgt_ff[1] <= 32'sh0; rgt_ff[2] <= 32'sh0;
         up_ff[0] <= 32'sh0; up_ff[1] <= 32'sh00010000; up_ff[2] <= 32'sh0;
      end else begin
         pos_ff <= pos_in; fwd_ff <= fwd_in; rgt_ff <= rgt_in; up_ff <= up_in;
      end
      item_ff <= item_in; cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      neg_ff <= neg_in; out_ff <= out_in;
      acc_ff <= acc_in; na_ff <= na_in;
   end

   `CBRM_ASSERT(a_step_range, clock, reset, (cmd.op == CMD_CORDIC) |-> (cmd.step < 5'(MaxSteps)), "cordic step out of range")
   `CBRM_ASSERT(a_comp_range, clock, reset, (cmd.op == CMD_SHIFT || cmd.op == CMD_TURN_B) |-> (cmd.comp < 2'd3), "component index out of range")
   `CBRM_ASSERT(a_load_op, clock, reset, (cmd.op == CMD_LOAD) |-> (item_ff.op == OP_LOAD), "load without load item")

endmodule

FILE: hdl/cbrm_control.sv
// Controller: sequences one item through the datapath.
`include "camera_basis_rotate_move_unit_defines.svh"
module cbrm_control import cbrm_pkg::*; #(
   parameter int TRIG_ITERATIONS = TrigIterationsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] item_op,
   input  logic [1:0] item_axis,
   output cmd_type    cmd
);
   localparam int Steps = (TRIG_ITERATIONS > MaxSteps) ? MaxSteps : TRIG_ITERATIONS;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_CORDIC, S_PIV1, S_TA0, S_TB0, S_TA1, S_TB1,
      S_PIV2, S_MOVE, S_LOAD, S_OUT, S_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] comp_ff, comp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rotating;

   assign rotating  = (item_op == OP_ROTATE) && (item_axis != AX_POS);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff; step_in = step_ff; comp_in = comp_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '{op: CMD_NONE, step: step_ff, comp: comp_ff, sub: 3'd0,
              src_fwd: 1'b1, neg: 1'b0};
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.op = CMD_CAPTURE; state_in = S_DECODE;
         end
         S_DECODE: begin
            step_in = '0; comp_in = '0;
            if (rotating) state_in = S_CORDIC;
            else if (item_op == OP_MOVE && item_axis != AX_POS) state_in = S_MOVE;
            else if (item_op == OP_LOAD) state_in = S_LOAD;
            else state_in = S_OUT;
         end
         S_CORDIC: begin
            cmd.op = CMD_CORDIC; step_in = step_ff + 5'd1;
            if (step_ff == 5'(Steps - 1)) state_in = S_PIV1;
         end
         S_PIV1, S_PIV2, S_MOVE: begin
            cmd.op = CMD_SHIFT; cmd.src_fwd = (state_ff != S_MOVE);
            cmd.neg = (state_ff == S_PIV2);
            comp_in = comp_ff + 2'd1;
            if (comp_ff == 2'd2) begin
               comp_in = '0;
               state_in = (state_ff == S_PIV1) ? S_TA0 : S_OUT;
            end
         end
         S_TA0: begin cmd.op = CMD_TURN_A; cmd.sub = 3'd0; state_in = S_TB0; end
         S_TB0: begin cmd.op = CMD_TURN_B; cmd.sub = 3'd1; state_in = S_TA1; end
         S_TA1: begin cmd.op = CMD_TURN_A; cmd.sub = 3'd2; state_in = S_TB1; end
         S_TB1: begin
            cmd.op = CMD_TURN_B; cmd.sub = 3'd3;
            comp_in = comp_ff + 2'd1; state_in = S_TA0;
            if (comp_ff == 2'd2) begin comp_in = '0; state_in = S_PIV2; end
         end
         S_LOAD: begin cmd.op = CMD_LOAD; state_in = S_OUT; end
         S_OUT: if (!rsp_valid_ff || !rsp_stall) begin
            cmd.op = CMD_OUTPUT; rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; step_ff <= '0; comp_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; comp_ff <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CBRM_ASSERT(a_one_out, clock, reset, (cmd.op == CMD_OUTPUT) |=> rsp_valid, "output not flagged")
   `CBRM_ASSERT(a_no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> req_stall, "accept while busy")
   `CBRM_ASSERT(a_comp_ok, clock, reset, comp_ff != 2'd3, "component counter overran")

endmodule

FILE: hdl/camera_basis_rotate_move_unit.sv
// Top level of the camera basis rotate/move unit.
// One request beat at a time. A read passes decode and output, a load adds
// the load step, a move one three-component shift, and a rotation runs decode,
// CORDIC steps, two three-component pivot moves and three turn steps through
// one shared multiplier. The request channel stalls while an item is in
// work; a finished response beat waits in its register and the next request
// may be taken meanwhile. An item only waits at output when its response finds
// the previous one still stalled. Reset puts the camera at (0,-1,8) looking
// down -Z.
module camera_basis_rotate_move_unit import cbrm_pkg::*; #(
   parameter int TRIG_ITERATIONS = TrigIterationsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cmd_type    cmd;
   logic [1:0] item_op, item_axis;

   cbrm_control #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_ctl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .item_op, .item_axis, .cmd
   );

   cbrm_datapath u_dp (
      .clock, .reset, .cmd, .req_data, .item_op, .item_axis, .rsp_data
   );
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for the camera basis rotate/move unit: random and directed beats, scoreboard check.
module tb;
   import cbrm_pkg::*;

   localparam int      TRIG_STEPS  = TrigIterationsDefault;
   localparam longint  HALF_PI_Q30 = 64'sd1686629713;
   localparam longint  PI_Q30      = 64'sd3373259426;
   localparam longint  GAIN_Q30    = 64'sd652032874;
   localparam longint  CYCLE_LIMIT = 64'd2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   camera_basis_rotate_move_unit #(.TRIG_ITERATIONS(TRIG_STEPS)) uut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Camera state predictor plus queue of expected view beats.
   class camera_scoreboard;
      logic [31:0] pos[3], fwd[3], rgt[3], up[3];
      rsp_type     view_q[$];
      int          errors, beats_in, beats_out, rotations;

      function void home();
         pos = '{32'h0, 32'hFFFF0000, 32'h00080000};
         fwd = '{32'h0, 32'h0, 32'hFFFF0000};
         rgt = '{32'h00010000, 32'h0, 32'h0};
         up  = '{32'h0, 32'h00010000, 32'h0};
      endfunction

      // arithmetic shift right keeps floor semantics
      function longint atan_step(int i);
         longint tbl[24] = '{843314857, 497837830, 263043837, 133525159, 67021688,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
            262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128};
         return tbl[i];
      endfunction

      function void sincos(longint theta, output longint s, output longint c);
         longint x, y, z, dx, dy;
         bit     flip;
         int     n;
         x = GAIN_Q30; y = 0; flip = 0;
         if (theta > HALF_PI_Q30) begin
            theta -= PI_Q30; flip = 1;
         end else if (theta < -HALF_PI_Q30) begin
            theta += PI_Q30; flip = 1;
         end
         z = theta;
         n = (TRIG_STEPS > 24) ? 24 : TRIG_STEPS;
         for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_step(i);
            end else begin
               x += dx; y -= dy; z += atan_step(i);
            end
         end
         s = flip ? -y : y;
         c = flip ? -x : x;
      endfunction

      // pair turn: a' = a*c + b*s, b' = b*c - a*s, rounded from Q30
      function void turn(ref logic [31:0] a[3], ref logic [31:0] b[3], input longint s,
                         input longint c);
         longint av, bv;
         for (int k = 0; k < 3; k++) begin
            av = longint'(signed'(a[k]));
            bv = longint'(signed'(b[k]));
            a[k] = 32'((av * c + bv * s + (64'sd1 <<< 29)) >>> 30);
            b[k] = 32'((bv * c - av * s + (64'sd1 <<< 29)) >>> 30);
         end
      endfunction

      function void step_along(logic [31:0] v[3], longint d);
         longint st;
         for (int k = 0; k < 3; k++) begin
            st = (longint'(signed'(v[k])) * d + 64'sd32768) >>> 16;
            pos[k] = 32'(longint'(signed'(pos[k])) + st);
         end
      endfunction

      function void note_request(req_type r);
         longint  s, c, d;
         rsp_type v;
         d = longint'(r.distance);
         beats_in++;
         case (r.op)
            OP_ROTATE: if (r.axis != AX_POS) begin
               rotations++;
               sincos(longint'(r.angle) * 131072, s, c);
               step_along(fwd, d);
               if (r.axis == AX_FWD) turn(fwd, up, s, c);
               else if (r.axis == AX_RGT) turn(fwd, rgt, s, c);
               else turn(up, rgt, s, c);
               step_along(fwd, -d);
            end
            OP_MOVE: begin
               if (r.axis == AX_FWD) step_along(fwd, d);
               else if (r.axis == AX_RGT) step_along(rgt, d);
               else if (r.axis == AX_UP) step_along(up, d);
            end
            OP_LOAD: begin
               case (r.axis)
                  AX_FWD: fwd = '{r.load_x, r.load_y, r.load_z};
                  AX_RGT: rgt = '{r.load_x, r.load_y, r.load_z};
                  AX_UP:  up  = '{r.load_x, r.load_y, r.load_z};
                  default: pos = '{r.load_x, r.load_y, r.load_z};
               endcase
            end
            default: ;
         endcase
         v.pos_x = pos[0]; v.pos_y = pos[1]; v.pos_z = pos[2];
         v.look_x = pos[0] + fwd[0]; v.look_y = pos[1] + fwd[1];
         v.look_z = pos[2] + fwd[2];
         v.up_out_x = up[0]; v.up_out_y = up[1]; v.up_out_z = up[2];
         view_q.push_back(v);
      endfunction

      function void check_view(rsp_type got);
         rsp_type w;
         beats_out++;
         if (view_q.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
            return;
         end
         w = view_q.pop_front();
         if (got.pos_x !== w.pos_x) begin
            $error("pos_x exp %h got %h", w.pos_x, got.pos_x); errors++;
         end
         if (got.pos_y !== w.pos_y) begin
            $error("pos_y exp %h got %h", w.pos_y, got.pos_y); errors++;
         end
         if (got.pos_z !== w.pos_z) begin
            $error("pos_z exp %h got %h", w.pos_z, got.pos_z); errors++;
         end
         if (got.look_x !== w.look_x) begin
            $error("look_x exp %h got %h", w.look_x, got.look_x); errors++;
         end
         if (got.look_y !== w.look_y) begin
            $error("look_y exp %h got %h", w.look_y, got.look_y); errors++;
         end
         if (got.look_z !== w.look_z) begin
            $error("look_z exp %h got %h", w.look_z, got.look_z); errors++;
         end
         if (got.up_out_x !== w.up_out_x) begin
            $error("up_out_x exp %h got %h", w.up_out_x, got.up_out_x); errors++;
         end
         if (got.up_out_y !== w.up_out_y) begin
            $error("up_out_y exp %h got %h", w.up_out_y, got.up_out_y); errors++;
         end
         if (got.up_out_z !== w.up_out_z) begin
            $error("up_out_z exp %h got %h", w.up_out_z, got.up_out_z); errors++;
         end
      endfunction
   endclass

   camera_scoreboard board = new();

   // idle percentages for each side, changed per phase
   int     send_idle_pct = 0;
   int     stall_pct = 0;
   longint cycles = 0;

   // Monitor: both channels sampled at the edge, before driven updates land.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_view(rsp_data);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Send one beat; holds valid until accepted, optional idle cycles first.
   task automatic send_beat(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic req_type make_beat(logic [1:0] op, logic [1:0] axis,
                                         logic [15:0] ang, logic [31:0] span);
      req_type r;
      r.op = op; r.axis = axis; r.angle = ang; r.distance = span;
      r.load_x = $urandom(); r.load_y = $urandom(); r.load_z = $urandom();
      return r;
   endfunction

   // Mostly small, camera-like values so rotations stay meaningful; a few wide.
   function automatic req_type random_beat();
      req_type r;
      int      pick;
      r = make_beat(2'($urandom_range(3)), 2'($urandom_range(3)), 16'($urandom()),
                    32'($urandom()));
      pick = $urandom_range(9);
      if (pick < 7) r.distance = 32'(signed'($urandom_range(1 << 20)) - (1 << 19));
      if (r.op == OP_LOAD && $urandom_range(3) != 0) begin
         r.load_x = 32'(signed'($urandom_range(1 << 18)) - (1 << 17));
         r.load_y = 32'(signed'($urandom_range(1 << 18)) - (1 << 17));
         r.load_z = 32'(signed'($urandom_range(1 << 18)) - (1 << 17));
      end
      return r;
   endfunction

   initial begin
      req_type r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: each op and axis, angle extremes, half-pi folding, pivots
      send_beat(make_beat(OP_READ, AX_FWD, 16'h0000, 32'h0));
      for (int a = 0; a < 4; a++) send_beat(make_beat(OP_ROTATE, 2'(a), 16'h3244, 32'h0));
      send_beat(make_beat(OP_ROTATE, AX_FWD, 16'h7FFF, 32'h0));
      send_beat(make_beat(OP_ROTATE, AX_RGT, 16'h8000, 32'h00020000));
      send_beat(make_beat(OP_ROTATE, AX_UP, 16'hCDBC, 32'hFFFE0000));
      send_beat(make_beat(OP_ROTATE, AX_RGT, 16'h3243, 32'h7FFFFFFF));
      send_beat(make_beat(OP_ROTATE, AX_FWD, 16'h0001, 32'h80000000));
      for (int a = 0; a < 4; a++) send_beat(make_beat(OP_MOVE, 2'(a), 16'h0, 32'h00018000));
      send_beat(make_beat(OP_MOVE, AX_FWD, 16'hFFFF, 32'h7FFFFFFF));
      send_beat(make_beat(OP_MOVE, AX_RGT, 16'h0, 32'h80000000));
      for (int a = 0; a < 4; a++) begin
         r = make_beat(OP_LOAD, 2'(a), 16'h0, 32'h0);
         if (a == 1) r.load_x = 32'h7FFFFFFF;
         if (a == 2) r.load_y = 32'h80000000;
         send_beat(r);
      end
      send_beat(make_beat(OP_READ, AX_POS, 16'hFFFF, 32'hFFFFFFFF));

      // random, in idling phases: none, sender, receiver, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 69 : (ph == 3) ? 21 : 0;
         stall_pct     = (ph == 2) ? 69 : (ph == 3) ? 21 : 0;
         for (int i = 0; i < 250; i++) send_beat(random_beat());
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      while (board.view_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d request beats (%0d rotations), checked %0d responses",
               board.beats_in, board.rotations, board.beats_out);
      $display("idling phases: none, sender 69%%, receiver 69%%, both 21%%");
      if (board.errors == 0 && board.view_q.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial board.home();
endmodule
